// ----- design/sads_pkg.sv -----
package sads_pkg;

  // Fixed-point format and lattice size
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NB_SLOTS  = 6;

  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic signed [31:0] Q_HALF  = 32'sd32768;
  localparam logic signed [31:0] Q_C866  = 32'sd56754;
  localparam logic signed [32:0] Q_TWO_PI = 33'sd411774;

  // Register reset values
  localparam logic [15:0] TS_RESET      = 16'd3277;
  localparam logic [23:0] SPACING_RESET = 24'd1310720;
  localparam logic [23:0] PROP_RESET    = 24'd1310720;
  localparam logic [23:0] VISC_RESET    = 24'd327680;
  localparam logic [23:0] SPRING_RESET  = 24'd6554;
  localparam logic [23:0] ANISO_RESET   = 24'd32768;
  localparam logic [23:0] ISTR_RESET    = 24'd6553600;
  localparam logic [23:0] PREF_RESET    = 24'd1310720;

  // Agent state reset values
  localparam logic signed [31:0] PX_RESET = 32'sd176947;
  localparam logic signed [31:0] PY_RESET = 32'sd4954522;
  localparam logic signed [31:0] VX_RESET = 32'sd249037;
  localparam logic signed [31:0] VY_RESET = 32'sd85197;

  // Register indexes
  localparam logic [2:0] REG_TIME_STEP   = 3'd0;
  localparam logic [2:0] REG_SPACING     = 3'd1;
  localparam logic [2:0] REG_PROPULSION  = 3'd2;
  localparam logic [2:0] REG_VISCOSITY   = 3'd3;
  localparam logic [2:0] REG_SPRING      = 3'd4;
  localparam logic [2:0] REG_ANISOTROPY  = 3'd5;
  localparam logic [2:0] REG_INTERACTION = 3'd6;
  localparam logic [2:0] REG_PREFERRED   = 3'd7;

  // Request opcodes
  localparam logic OP_NB_WRITE = 1'b0;
  localparam logic OP_STEP     = 1'b1;

  // CORDIC constants, Q30
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_SHIFT = 30 - FRAC_BITS;
  localparam logic signed [34:0] PI_Q30         = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30    = 35'sd1686629713;
  localparam logic signed [34:0] THREE_HALF_Q30 = 35'sd5059889139;
  localparam logic signed [34:0] TWO_PI_Q30     = 35'sd6746518852;
  localparam logic signed [33:0] GAIN_Q30       = 34'sd652032874;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_SQRT, OP_DIV, OP_CORDIC, OP_HWRAP
  } alu_op_t;

  // Operand sources; the writable ones double as destinations
  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ONE, SRC_T0, SRC_T1, SRC_DX, SRC_DY, SRC_UX, SRC_UY,
    SRC_QV, SRC_ALPH, SRC_DVX, SRC_DVY, SRC_FXS, SRC_FYS, SRC_SN, SRC_CS,
    SRC_PX, SRC_PY, SRC_VX, SRC_VY, SRC_TS, SRC_SPACING, SRC_PROP, SRC_VISC,
    SRC_SPRING, SRC_ANISO, SRC_ISTR, SRC_PREF, SRC_NX, SRC_NY, SRC_HDX, SRC_HDY
  } src_t;

  // Sequencing after a micro-op completes
  typedef enum logic [2:0] {
    CTL_NONE, CTL_TO_CHECK, CTL_SKIP_SLOT, CTL_NEXT_SLOT, CTL_SKIP_HEAD, CTL_DONE
  } ctl_t;

  typedef struct packed {
    alu_op_t op;
    src_t    a;
    src_t    b;
    src_t    dst;
    ctl_t    ctl;
  } uop_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    src_t    src_a;
    src_t    src_b;
    src_t    dst;
    logic [2:0] slot;
    logic    nb_write;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } dp_stat_t;

  // Program entry points
  localparam logic [5:0] LOOP_PC = 6'd9;
  localparam logic [5:0] POST_PC = 6'd34;
  localparam logic [5:0] UPD_PC  = 6'd48;

  function automatic uop_t uop_at(input logic [5:0] pc);
    uop_t u;
    case (pc)
      // propulsion and drag
      6'd0:  u = '{OP_CORDIC, SRC_ZERO, SRC_ZERO, SRC_ZERO, CTL_NONE};
      6'd1:  u = '{OP_MUL, SRC_PROP, SRC_CS, SRC_T0, CTL_NONE};
      6'd2:  u = '{OP_MUL, SRC_VISC, SRC_VX, SRC_T1, CTL_NONE};
      6'd3:  u = '{OP_SUB, SRC_T0, SRC_T1, SRC_DVX, CTL_NONE};
      6'd4:  u = '{OP_MUL, SRC_PROP, SRC_SN, SRC_T0, CTL_NONE};
      6'd5:  u = '{OP_MUL, SRC_VISC, SRC_VY, SRC_T1, CTL_NONE};
      6'd6:  u = '{OP_SUB, SRC_T0, SRC_T1, SRC_DVY, CTL_NONE};
      6'd7:  u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SRC_FXS, CTL_NONE};
      6'd8:  u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SRC_FYS, CTL_TO_CHECK};
      // pair force of one neighbor
      6'd9:  u = '{OP_MUL, SRC_SPACING, SRC_HDX, SRC_T0, CTL_NONE};
      6'd10: u = '{OP_ADD, SRC_NX, SRC_T0, SRC_T0, CTL_NONE};
      6'd11: u = '{OP_SUB, SRC_T0, SRC_PX, SRC_DX, CTL_NONE};
      6'd12: u = '{OP_MUL, SRC_SPACING, SRC_HDY, SRC_T0, CTL_NONE};
      6'd13: u = '{OP_ADD, SRC_NY, SRC_T0, SRC_T0, CTL_NONE};
      6'd14: u = '{OP_SUB, SRC_T0, SRC_PY, SRC_DY, CTL_NONE};
      6'd15: u = '{OP_SQRT, SRC_DX, SRC_DY, SRC_ZERO, CTL_SKIP_SLOT};
      6'd16: u = '{OP_DIV, SRC_DX, SRC_ZERO, SRC_UX, CTL_NONE};
      6'd17: u = '{OP_DIV, SRC_DY, SRC_ZERO, SRC_UY, CTL_NONE};
      6'd18: u = '{OP_DIV, SRC_PREF, SRC_ZERO, SRC_QV, CTL_NONE};
      6'd19: u = '{OP_MUL, SRC_UX, SRC_CS, SRC_T0, CTL_NONE};
      6'd20: u = '{OP_MUL, SRC_UY, SRC_SN, SRC_T1, CTL_NONE};
      6'd21: u = '{OP_ADD, SRC_T0, SRC_T1, SRC_T0, CTL_NONE};
      6'd22: u = '{OP_MUL, SRC_ANISO, SRC_T0, SRC_T0, CTL_NONE};
      6'd23: u = '{OP_ADD, SRC_ONE, SRC_T0, SRC_ALPH, CTL_NONE};
      6'd24: u = '{OP_SUB, SRC_QV, SRC_ONE, SRC_T0, CTL_NONE};
      6'd25: u = '{OP_MUL, SRC_ISTR, SRC_T0, SRC_T0, CTL_NONE};
      6'd26: u = '{OP_MUL, SRC_T0, SRC_QV, SRC_T0, CTL_NONE};
      6'd27: u = '{OP_MUL, SRC_T0, SRC_QV, SRC_T0, CTL_NONE};
      6'd28: u = '{OP_SUB, SRC_ZERO, SRC_T0, SRC_T0, CTL_NONE};
      6'd29: u = '{OP_MUL, SRC_ALPH, SRC_T0, SRC_T0, CTL_NONE};
      6'd30: u = '{OP_MUL, SRC_T0, SRC_UX, SRC_T1, CTL_NONE};
      6'd31: u = '{OP_ADD, SRC_FXS, SRC_T1, SRC_FXS, CTL_NONE};
      6'd32: u = '{OP_MUL, SRC_T0, SRC_UY, SRC_T1, CTL_NONE};
      6'd33: u = '{OP_ADD, SRC_FYS, SRC_T1, SRC_FYS, CTL_NEXT_SLOT};
      // spring and heading
      6'd34: u = '{OP_ADD, SRC_DVX, SRC_FXS, SRC_T0, CTL_NONE};
      6'd35: u = '{OP_MUL, SRC_SPRING, SRC_PX, SRC_T1, CTL_NONE};
      6'd36: u = '{OP_SUB, SRC_T0, SRC_T1, SRC_DVX, CTL_NONE};
      6'd37: u = '{OP_ADD, SRC_DVY, SRC_FYS, SRC_T0, CTL_NONE};
      6'd38: u = '{OP_MUL, SRC_SPRING, SRC_PY, SRC_T1, CTL_NONE};
      6'd39: u = '{OP_SUB, SRC_T0, SRC_T1, SRC_DVY, CTL_NONE};
      6'd40: u = '{OP_SQRT, SRC_VX, SRC_VY, SRC_ZERO, CTL_SKIP_HEAD};
      6'd41: u = '{OP_DIV, SRC_VY, SRC_ZERO, SRC_T0, CTL_NONE};
      6'd42: u = '{OP_MUL, SRC_CS, SRC_T0, SRC_T0, CTL_NONE};
      6'd43: u = '{OP_DIV, SRC_VX, SRC_ZERO, SRC_T1, CTL_NONE};
      6'd44: u = '{OP_MUL, SRC_SN, SRC_T1, SRC_T1, CTL_NONE};
      6'd45: u = '{OP_SUB, SRC_T0, SRC_T1, SRC_T0, CTL_NONE};
      6'd46: u = '{OP_MUL, SRC_T0, SRC_TS, SRC_T0, CTL_NONE};
      6'd47: u = '{OP_HWRAP, SRC_T0, SRC_ZERO, SRC_ZERO, CTL_NONE};
      // velocity, then position
      6'd48: u = '{OP_MUL, SRC_DVX, SRC_TS, SRC_T0, CTL_NONE};
      6'd49: u = '{OP_ADD, SRC_VX, SRC_T0, SRC_VX, CTL_NONE};
      6'd50: u = '{OP_MUL, SRC_DVY, SRC_TS, SRC_T0, CTL_NONE};
      6'd51: u = '{OP_ADD, SRC_VY, SRC_T0, SRC_VY, CTL_NONE};
      6'd52: u = '{OP_MUL, SRC_VX, SRC_TS, SRC_T0, CTL_NONE};
      6'd53: u = '{OP_ADD, SRC_PX, SRC_T0, SRC_PX, CTL_NONE};
      6'd54: u = '{OP_MUL, SRC_VY, SRC_TS, SRC_T0, CTL_NONE};
      6'd55: u = '{OP_ADD, SRC_PY, SRC_T0, SRC_PY, CTL_DONE};
      default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, CTL_DONE};
    endcase
    return u;
  endfunction

  function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Hexagonal offsets by slot
  function automatic logic signed [31:0] hex_dx(input logic [2:0] slot);
    logic signed [31:0] r;
    case (slot)
      3'd0: r = Q_C866;
      3'd1: r = -Q_C866;
      3'd2: r = -Q_ONE;
      3'd3: r = -Q_C866;
      3'd4: r = Q_ONE;
      3'd5: r = Q_C866;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] hex_dy(input logic [2:0] slot);
    logic signed [31:0] r;
    case (slot)
      3'd0, 3'd1: r = Q_HALF;
      3'd3, 3'd5: r = -Q_HALF;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // atan(2^-i) in Q30
  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    logic signed [34:0] r;
    case (i)
      5'd0:  r = 35'sd843314856;
      5'd1:  r = 35'sd497837829;
      5'd2:  r = 35'sd263043837;
      5'd3:  r = 35'sd133525159;
      5'd4:  r = 35'sd67021687;
      5'd5:  r = 35'sd33543516;
      5'd6:  r = 35'sd16775851;
      5'd7:  r = 35'sd8388437;
      5'd8:  r = 35'sd4194283;
      5'd9:  r = 35'sd2097149;
      5'd10: r = 35'sd1048576;
      5'd11: r = 35'sd524288;
      5'd12: r = 35'sd262144;
      5'd13: r = 35'sd131072;
      5'd14: r = 35'sd65536;
      5'd15: r = 35'sd32768;
      5'd16: r = 35'sd16384;
      5'd17: r = 35'sd8192;
      5'd18: r = 35'sd4096;
      5'd19: r = 35'sd2048;
      5'd20: r = 35'sd1024;
      5'd21: r = 35'sd512;
      5'd22: r = 35'sd256;
      5'd23: r = 35'sd128;
      5'd24: r = 35'sd64;
      5'd25: r = 35'sd32;
      5'd26: r = 35'sd16;
      5'd27: r = 35'sd8;
      5'd28: r = 35'sd4;
      5'd29: r = 35'sd2;
      default: r = 35'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/sads_req_if.sv -----
interface sads_req_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic [2:0]        neighbor_index;
  logic signed [31:0] neighbor_x;
  logic signed [31:0] neighbor_y;
  logic [5:0]        connected_mask;

  modport source (output valid, op, neighbor_index, neighbor_x, neighbor_y,
                  connected_mask, input ready);
  modport sink (input valid, op, neighbor_index, neighbor_x, neighbor_y,
                connected_mask, output ready);
endinterface

// ----- design/sads_res_if.sv -----
interface sads_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;
  logic [18:0]        heading;

  modport source (output valid, position_x, position_y, velocity_x, velocity_y,
                  heading, input ready);
  modport sink (input valid, position_x, position_y, velocity_x, velocity_y,
                heading, output ready);
endinterface

// ----- design/sads_ctrl.sv -----
module sads_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_op,
  input  logic [5:0]          req_mask,
  output logic                req_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output sads_pkg::dp_cmd_t   cmd,
  input  sads_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_FINISH} state_t;

  state_t           state;
  logic [5:0]       pc;
  logic [2:0]       slot;
  logic [5:0]       mask;
  sads_pkg::uop_t   uop;

  assign uop = sads_pkg::uop_at(pc);

  // Commands to the datapath
  always_comb begin
    req_ready    = (state == S_IDLE);
    cmd.start    = (state == S_ISSUE);
    cmd.op       = uop.op;
    cmd.src_a    = uop.a;
    cmd.src_b    = uop.b;
    cmd.dst      = uop.dst;
    cmd.slot     = slot;
    cmd.nb_write = (state == S_IDLE) && req_valid && (req_op == sads_pkg::OP_NB_WRITE);
    cmd.load_out = (state == S_FINISH) && (!res_valid || res_ready);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      pc        <= '0;
      slot      <= '0;
      mask      <= '0;
    end else begin
      // result taken; a finishing step reloads it below
      if (res_valid && res_ready && state != S_FINISH) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid && req_op == sads_pkg::OP_STEP) begin
            mask  <= req_mask;
            pc    <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (stat.done) begin
            case (uop.ctl)
              sads_pkg::CTL_TO_CHECK: begin
                slot  <= '0;
                state <= S_CHECK;
              end
              sads_pkg::CTL_SKIP_SLOT: begin
                if (stat.zero) begin
                  slot  <= slot + 3'd1;
                  state <= S_CHECK;
                end else begin
                  pc    <= pc + 6'd1;
                  state <= S_ISSUE;
                end
              end
              sads_pkg::CTL_NEXT_SLOT: begin
                slot  <= slot + 3'd1;
                state <= S_CHECK;
              end
              sads_pkg::CTL_SKIP_HEAD: begin
                pc    <= stat.zero ? sads_pkg::UPD_PC : pc + 6'd1;
                state <= S_ISSUE;
              end
              sads_pkg::CTL_DONE: state <= S_FINISH;
              default: begin
                pc    <= pc + 6'd1;
                state <= S_ISSUE;
              end
            endcase
          end
        end
        S_CHECK: begin
          // walk the slots, entering the pair-force program for connected ones
          if (slot == 3'(sads_pkg::NB_SLOTS)) begin
            pc    <= sads_pkg::POST_PC;
            state <= S_ISSUE;
          end else if (mask[slot]) begin
            pc    <= sads_pkg::LOOP_PC;
            state <= S_ISSUE;
          end else begin
            slot <= slot + 3'd1;
          end
        end
        S_FINISH: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/sads_dp.sv -----
module sads_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [2:0]          nb_index,
  input  logic signed [31:0]  nb_x,
  input  logic signed [31:0]  nb_y,
  input  sads_pkg::dp_cmd_t   cmd,
  output sads_pkg::dp_stat_t  stat,
  output logic signed [31:0]  out_px,
  output logic signed [31:0]  out_py,
  output logic signed [31:0]  out_vx,
  output logic signed [31:0]  out_vy,
  output logic [18:0]         out_heading
);

  typedef enum logic [2:0] {U_IDLE, U_SQ2, U_ROOT, U_DIV, U_CORDIC} unit_t;

  // Configuration
  logic [15:0] time_step;
  logic [23:0] spacing, propulsion, viscosity, spring, aniso, istr, pref;

  // Agent and neighbor state
  logic signed [31:0] px, py, vx, vy;
  logic [18:0]        heading;
  logic signed [31:0] nbx [sads_pkg::NB_SLOTS];
  logic signed [31:0] nby [sads_pkg::NB_SLOTS];

  // Working registers
  logic signed [31:0] t0, t1, dx, dy, ux, uy, qv, alph, dvx, dvy, fxs, fys, sn, cs;

  unit_t       ustate;
  logic        done, zero;
  logic [31:0] root_q;

  // isqrt
  logic [63:0] sq_acc, rx, rres, rbit, rsum, rres_n;
  logic [31:0] mag_b;
  logic [4:0]  riter;
  logic        rge;

  // divider
  logic [47:0] dvd, dvd_n;
  logic [31:0] rem, rem_n;
  logic [32:0] dsh, qc;
  logic [5:0]  dcnt;
  logic        dge;
  logic signed [65:0] dsig;
  logic signed [31:0] div_res;

  // CORDIC
  logic signed [33:0] cx, cy, cx_n, cy_n, cxs, cys, fx, fy, cr_x, cr_y;
  logic signed [34:0] ct, ct_n, cat, tfold;
  logic [4:0]         ci;
  logic               cflip, fflip;

  // operands, multiplier
  logic signed [31:0] opa, opb, mul_q, wb_val;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p, mul_r;
  logic signed [32:0] hsum, hwrap;
  logic               wb_en;

  assign stat.done = done;
  assign stat.zero = zero;

  // Operand select
  function automatic logic signed [31:0] pick(input sads_pkg::src_t s,
                                              input logic [2:0] slot_i);
    logic signed [31:0] r;
    case (s)
      sads_pkg::SRC_ZERO:    r = 32'sd0;
      sads_pkg::SRC_ONE:     r = sads_pkg::Q_ONE;
      sads_pkg::SRC_T0:      r = t0;
      sads_pkg::SRC_T1:      r = t1;
      sads_pkg::SRC_DX:      r = dx;
      sads_pkg::SRC_DY:      r = dy;
      sads_pkg::SRC_UX:      r = ux;
      sads_pkg::SRC_UY:      r = uy;
      sads_pkg::SRC_QV:      r = qv;
      sads_pkg::SRC_ALPH:    r = alph;
      sads_pkg::SRC_DVX:     r = dvx;
      sads_pkg::SRC_DVY:     r = dvy;
      sads_pkg::SRC_FXS:     r = fxs;
      sads_pkg::SRC_FYS:     r = fys;
      sads_pkg::SRC_SN:      r = sn;
      sads_pkg::SRC_CS:      r = cs;
      sads_pkg::SRC_PX:      r = px;
      sads_pkg::SRC_PY:      r = py;
      sads_pkg::SRC_VX:      r = vx;
      sads_pkg::SRC_VY:      r = vy;
      sads_pkg::SRC_TS:      r = {16'd0, time_step};
      sads_pkg::SRC_SPACING: r = {8'd0, spacing};
      sads_pkg::SRC_PROP:    r = {8'd0, propulsion};
      sads_pkg::SRC_VISC:    r = {8'd0, viscosity};
      sads_pkg::SRC_SPRING:  r = {8'd0, spring};
      sads_pkg::SRC_ANISO:   r = {8'd0, aniso};
      sads_pkg::SRC_ISTR:    r = {8'd0, istr};
      sads_pkg::SRC_PREF:    r = {8'd0, pref};
      sads_pkg::SRC_NX:      r = nbx[slot_i];
      sads_pkg::SRC_NY:      r = nby[slot_i];
      sads_pkg::SRC_HDX:     r = sads_pkg::hex_dx(slot_i);
      sads_pkg::SRC_HDY:     r = sads_pkg::hex_dy(slot_i);
      default:               r = 32'sd0;
    endcase
    return r;
  endfunction

  assign opa = pick(cmd.src_a, cmd.slot);
  assign opb = pick(cmd.src_b, cmd.slot);

  // Shared multiplier: signed product for qmul, magnitudes for squares
  always_comb begin
    if (ustate == U_SQ2) begin
      mul_a = {1'b0, mag_b};
      mul_b = {1'b0, mag_b};
    end else if (cmd.op == sads_pkg::OP_SQRT) begin
      mul_a = {1'b0, sads_pkg::mag32(opa)};
      mul_b = {1'b0, sads_pkg::mag32(opa)};
    end else begin
      mul_a = {opa[31], opa};
      mul_b = {opb[31], opb};
    end
    mul_p = mul_a * mul_b;
    mul_r = (mul_p + 66'sd32768) >>> sads_pkg::FRAC_BITS;
    mul_q = sads_pkg::sat32(mul_r);
  end

  // isqrt step, one result bit per cycle
  always_comb begin
    rbit   = 64'd1 << {riter, 1'b0};
    rsum   = rres + rbit;
    rge    = (rx >= rsum);
    rres_n = rge ? ((rres >> 1) + rbit) : (rres >> 1);
  end

  // Restoring divide of |a| << 16 by the root, then clamp and sign
  always_comb begin
    dsh   = {rem, dvd[47]};
    dge   = (dsh >= {1'b0, root_q});
    rem_n = dge ? 32'(dsh - {1'b0, root_q}) : dsh[31:0];
    dvd_n = {dvd[46:0], dge};
    qc    = (dvd_n > 48'h0000_8000_0000) ? 33'h0_8000_0000 : dvd_n[32:0];
    dsig  = opa[31] ? -$signed({33'd0, qc}) : $signed({33'd0, qc});
    div_res = sads_pkg::sat32(dsig);
  end

  // CORDIC rotation step and final rounding
  always_comb begin
    cxs = cx >>> ci;
    cys = cy >>> ci;
    cat = sads_pkg::atan_q30(ci);
    if (!ct[34]) begin
      cx_n = cx - cys;
      cy_n = cy + cxs;
      ct_n = ct - cat;
    end else begin
      cx_n = cx + cys;
      cy_n = cy - cxs;
      ct_n = ct + cat;
    end
    fx   = cflip ? -cx_n : cx_n;
    fy   = cflip ? -cy_n : cy_n;
    cr_x = (fx + 34'sd8192) >>> sads_pkg::CORDIC_SHIFT;
    cr_y = (fy + 34'sd8192) >>> sads_pkg::CORDIC_SHIFT;
    // quadrant fold of the starting angle
    tfold = $signed({2'b00, heading, 14'd0});
    fflip = 1'b0;
    if (tfold > sads_pkg::THREE_HALF_Q30) begin
      tfold = tfold - sads_pkg::TWO_PI_Q30;
    end else if (tfold > sads_pkg::HALF_PI_Q30) begin
      tfold = tfold - sads_pkg::PI_Q30;
      fflip = 1'b1;
    end
  end

  // Heading update with wrap into [0, 2pi)
  always_comb begin
    hsum = $signed({14'd0, heading}) + $signed({opa[31], opa});
    if (hsum >= sads_pkg::Q_TWO_PI) hwrap = hsum - sads_pkg::Q_TWO_PI;
    else if (hsum < 33'sd0) hwrap = hsum + sads_pkg::Q_TWO_PI;
    else hwrap = hsum;
  end

  // Write-back selection for single-register results
  always_comb begin
    wb_en  = 1'b0;
    wb_val = mul_q;
    if (ustate == U_IDLE && cmd.start) begin
      case (cmd.op)
        sads_pkg::OP_MUL: begin
          wb_en  = 1'b1;
          wb_val = mul_q;
        end
        sads_pkg::OP_ADD: begin
          wb_en  = 1'b1;
          wb_val = sads_pkg::sat32(sads_pkg::sx66(opa) + sads_pkg::sx66(opb));
        end
        sads_pkg::OP_SUB: begin
          wb_en  = 1'b1;
          wb_val = sads_pkg::sat32(sads_pkg::sx66(opa) - sads_pkg::sx66(opb));
        end
        default: wb_en = 1'b0;
      endcase
    end else if (ustate == U_DIV && dcnt == 6'd47) begin
      wb_en  = 1'b1;
      wb_val = div_res;
    end
  end

  // Configuration and neighbor writes
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step  <= sads_pkg::TS_RESET;
      spacing    <= sads_pkg::SPACING_RESET;
      propulsion <= sads_pkg::PROP_RESET;
      viscosity  <= sads_pkg::VISC_RESET;
      spring     <= sads_pkg::SPRING_RESET;
      aniso      <= sads_pkg::ANISO_RESET;
      istr       <= sads_pkg::ISTR_RESET;
      pref       <= sads_pkg::PREF_RESET;
      for (int i = 0; i < sads_pkg::NB_SLOTS; i++) begin
        nbx[i] <= 32'sd0;
        nby[i] <= 32'sd0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sads_pkg::REG_TIME_STEP:   time_step  <= cfg_data[15:0];
          sads_pkg::REG_SPACING:     spacing    <= cfg_data;
          sads_pkg::REG_PROPULSION:  propulsion <= cfg_data;
          sads_pkg::REG_VISCOSITY:   viscosity  <= cfg_data;
          sads_pkg::REG_SPRING:      spring     <= cfg_data;
          sads_pkg::REG_ANISOTROPY:  aniso      <= cfg_data;
          sads_pkg::REG_INTERACTION: istr       <= cfg_data;
          sads_pkg::REG_PREFERRED:   pref       <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.nb_write && nb_index < 3'(sads_pkg::NB_SLOTS)) begin
        nbx[nb_index] <= nb_x;
        nby[nb_index] <= nb_y;
      end
    end
  end

  // Agent state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      px      <= sads_pkg::PX_RESET;
      py      <= sads_pkg::PY_RESET;
      vx      <= sads_pkg::VX_RESET;
      vy      <= sads_pkg::VY_RESET;
      heading <= '0;
    end else begin
      if (wb_en) begin
        case (cmd.dst)
          sads_pkg::SRC_PX: px <= wb_val;
          sads_pkg::SRC_PY: py <= wb_val;
          sads_pkg::SRC_VX: vx <= wb_val;
          sads_pkg::SRC_VY: vy <= wb_val;
          default: ;
        endcase
      end
      if (ustate == U_IDLE && cmd.start && cmd.op == sads_pkg::OP_HWRAP) begin
        heading <= hwrap[18:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      case (cmd.dst)
        sads_pkg::SRC_T0:   t0   <= wb_val;
        sads_pkg::SRC_T1:   t1   <= wb_val;
        sads_pkg::SRC_DX:   dx   <= wb_val;
        sads_pkg::SRC_DY:   dy   <= wb_val;
        sads_pkg::SRC_UX:   ux   <= wb_val;
        sads_pkg::SRC_UY:   uy   <= wb_val;
        sads_pkg::SRC_QV:   qv   <= wb_val;
        sads_pkg::SRC_ALPH: alph <= wb_val;
        sads_pkg::SRC_DVX:  dvx  <= wb_val;
        sads_pkg::SRC_DVY:  dvy  <= wb_val;
        sads_pkg::SRC_FXS:  fxs  <= wb_val;
        sads_pkg::SRC_FYS:  fys  <= wb_val;
        default: ;
      endcase
    end
    if (ustate == U_CORDIC && ci == 5'(sads_pkg::CORDIC_STEPS - 1)) begin
      cs <= 32'(cr_x);
      sn <= 32'(cr_y);
    end
    // result register
    if (cmd.load_out) begin
      out_px      <= px;
      out_py      <= py;
      out_vx      <= vx;
      out_vy      <= vy;
      out_heading <= heading;
    end
  end

  // Multi-cycle units
  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      done   <= 1'b0;
      zero   <= 1'b0;
    end else begin
      case (ustate)
        U_IDLE: begin
          // ops other than root, divide and CORDIC report done right away
          done <= cmd.start && !(cmd.op inside {sads_pkg::OP_SQRT, sads_pkg::OP_DIV,
                                                 sads_pkg::OP_CORDIC});
          if (cmd.start) begin
            case (cmd.op)
              sads_pkg::OP_SQRT: begin
                sq_acc <= mul_p[63:0];
                mag_b  <= sads_pkg::mag32(opb);
                ustate <= U_SQ2;
              end
              sads_pkg::OP_DIV: begin
                dvd    <= {sads_pkg::mag32(opa), 16'd0};
                rem    <= '0;
                dcnt   <= '0;
                ustate <= U_DIV;
              end
              sads_pkg::OP_CORDIC: begin
                cx     <= sads_pkg::GAIN_Q30;
                cy     <= '0;
                ct     <= tfold;
                cflip  <= fflip;
                ci     <= '0;
                ustate <= U_CORDIC;
              end
              default: ;
            endcase
          end
        end
        U_SQ2: begin
          done   <= 1'b0;
          rx     <= sq_acc + mul_p[63:0];
          zero   <= ((sq_acc + mul_p[63:0]) == 64'd0);
          rres   <= '0;
          riter  <= 5'd31;
          ustate <= U_ROOT;
        end
        U_ROOT: begin
          if (rge) rx <= rx - rsum;
          rres  <= rres_n;
          riter <= riter - 5'd1;
          done  <= (riter == 5'd0);
          if (riter == 5'd0) begin
            root_q <= rres_n[31:0];
            ustate <= U_IDLE;
          end
        end
        U_DIV: begin
          dvd  <= dvd_n;
          rem  <= rem_n;
          dcnt <= dcnt + 6'd1;
          done <= (dcnt == 6'd47);
          if (dcnt == 6'd47) begin
            ustate <= U_IDLE;
          end
        end
        U_CORDIC: begin
          cx <= cx_n;
          cy <= cy_n;
          ct <= ct_n;
          ci <= ci + 5'd1;
          done <= (ci == 5'(sads_pkg::CORDIC_STEPS - 1));
          if (ci == 5'(sads_pkg::CORDIC_STEPS - 1)) begin
            ustate <= U_IDLE;
          end
        end
        default: begin
          done   <= 1'b0;
          ustate <= U_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/swarm_agent_dynamics_step_core.sv -----
// One agent of a hexagonal swarm, advanced by fixed-point Euler steps.
// Requests arrive on the request channel (valid/ready). A request with op 0
// stores one neighbor position and gives no result.
// A request with op 1 runs one step and gives one item on the result channel:
// the new position, velocity and heading.
// A step runs as a micro-program on one shared datapath: a 33x33 multiplier,
// saturating adder, 32-step square root, 48-step divider and 30-step CORDIC.
// A neighbor whose target sits on the agent skips the rest of its pair-force
// work; the divider and root dominate the time a step takes.
// One step is in flight at a time; request ready is high only while idle.
// The result sits in an output register, so the block takes the next request
// while a result still waits; a finished step whose result cannot be
// loaded waits until the receiver takes the previous one.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once; the user
// must make them only while the block is idle, as the block does not enforce this.
// Synchronous reset restores registers, agent state and clears the neighbors.
module swarm_agent_dynamics_step_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  sads_req_if.sink     request,
  sads_res_if.source   result
);

  sads_pkg::dp_cmd_t  cmd;
  sads_pkg::dp_stat_t stat;

  sads_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_op    (request.op),
    .req_mask  (request.connected_mask),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sads_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .nb_index    (request.neighbor_index),
    .nb_x        (request.neighbor_x),
    .nb_y        (request.neighbor_y),
    .cmd         (cmd),
    .stat        (stat),
    .out_px      (result.position_x),
    .out_py      (result.position_y),
    .out_vx      (result.velocity_x),
    .out_vy      (result.velocity_y),
    .out_heading (result.heading)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import sads_pkg::*;

  localparam longint CYCLE_LIMIT = 10000000;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     LONG_HOLD = 4000;

  typedef struct {
    logic        op;
    logic [2:0]  slot;
    longint      nx;
    longint      ny;
    logic [5:0]  mask;
  } agent_req_t;

  typedef struct {
    longint px;
    longint py;
    longint vx;
    longint vy;
    longint hd;
  } agent_state_t;

  // Fixed-point agent dynamics predictor plus the queue of pending steps
  class DynamicsScoreboard;
    longint       regs[8];
    longint       px, py, vx, vy, hd;
    longint       nbx[6], nby[6];
    agent_state_t pending[$];
    int           errors;
    longint       hex_x[6];
    longint       hex_y[6];
    longint       atan_tab[30];

    function new();
      regs = '{TS_RESET, SPACING_RESET, PROP_RESET, VISC_RESET, SPRING_RESET,
               ANISO_RESET, ISTR_RESET, PREF_RESET};
      px = PX_RESET; py = PY_RESET; vx = VX_RESET; vy = VY_RESET; hd = 0;
      foreach (nbx[i]) begin
        nbx[i] = 0;
        nby[i] = 0;
      end
      hex_x = '{Q_C866, -Q_C866, -Q_ONE, -Q_C866, Q_ONE, Q_C866};
      hex_y = '{Q_HALF, Q_HALF, 0, -Q_HALF, 0, -Q_HALF};
      atan_tab = '{843314856, 497837829, 263043837, 133525159, 67021687, 33543516,
                   16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                   131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                   128, 64, 32, 16, 8, 4, 2};
      errors = 0;
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint fmul(longint a, longint b);
      return clip((a * b + longint'(Q_HALF)) >>> FRAC_BITS);
    endfunction

    function longint unsigned absval(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint fdiv(longint a, longint unsigned b);
      longint unsigned q;
      q = (absval(a) << FRAC_BITS) / b;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return clip(a < 0 ? -longint'(q) : longint'(q));
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // 30-step rotation with folding into the right half plane
    function void rotate(longint h, output longint sn, output longint cs);
      longint t, x, y, nx, pi, half_pi;
      bit     flip;
      pi = PI_Q30;
      half_pi = HALF_PI_Q30;
      t = h <<< CORDIC_SHIFT;
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (t > 3 * half_pi) t -= 2 * pi;
      else if (t > half_pi) begin
        t -= pi;
        flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
        if (t >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          t -= atan_tab[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          t += atan_tab[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      cs = (x + (64'sd1 <<< (CORDIC_SHIFT - 1))) >>> CORDIC_SHIFT;
      sn = (y + (64'sd1 <<< (CORDIC_SHIFT - 1))) >>> CORDIC_SHIFT;
    endfunction

    function void write_reg(int idx, longint v);
      regs[idx] = (idx == REG_TIME_STEP) ? (v & 64'hFFFF) : (v & 64'hFF_FFFF);
    endfunction

    // Advance the model by one accepted request
    function void note_request(agent_req_t r);
      longint sn, cs, dvx, dvy, fxs, fys, dx, dy, ux, uy, q, alph, f, ds, h;
      longint unsigned sq, span, vabs;
      agent_state_t s;
      if (r.op == OP_NB_WRITE) begin
        if (r.slot < NB_SLOTS) begin
          nbx[r.slot] = r.nx;
          nby[r.slot] = r.ny;
        end
        return;
      end
      rotate(hd, sn, cs);
      dvx = clip(fmul(regs[REG_PROPULSION], cs) - fmul(regs[REG_VISCOSITY], vx));
      dvy = clip(fmul(regs[REG_PROPULSION], sn) - fmul(regs[REG_VISCOSITY], vy));
      fxs = 0;
      fys = 0;
      for (int i = 0; i < 6; i++) begin
        if (r.mask[i]) begin
          dx = clip(clip(nbx[i] + fmul(regs[REG_SPACING], hex_x[i])) - px);
          dy = clip(clip(nby[i] + fmul(regs[REG_SPACING], hex_y[i])) - py);
          sq = absval(dx) * absval(dx) + absval(dy) * absval(dy);
          // target on top of the agent contributes nothing
          if (sq != 0) begin
            span = root(sq);
            ux = fdiv(dx, span);
            uy = fdiv(dy, span);
            q = fdiv(regs[REG_PREFERRED], span);
            alph = clip(Q_ONE + fmul(regs[REG_ANISOTROPY],
                                     clip(fmul(ux, cs) + fmul(uy, sn))));
            f = fmul(regs[REG_INTERACTION], clip(q - Q_ONE));
            f = fmul(f, q);
            f = clip(-fmul(f, q));
            f = fmul(alph, f);
            fxs = clip(fxs + fmul(f, ux));
            fys = clip(fys + fmul(f, uy));
          end
        end
      end
      dvx = clip(clip(dvx + fxs) - fmul(regs[REG_SPRING], px));
      dvy = clip(clip(dvy + fys) - fmul(regs[REG_SPRING], py));
      sq = absval(vx) * absval(vx) + absval(vy) * absval(vy);
      // heading holds while the agent is at rest
      if (sq != 0) begin
        vabs = root(sq);
        ds = clip(fmul(cs, fdiv(vy, vabs)) - fmul(sn, fdiv(vx, vabs)));
        h = hd + fmul(ds, regs[REG_TIME_STEP]);
        if (h >= Q_TWO_PI) h -= Q_TWO_PI;
        else if (h < 0) h += Q_TWO_PI;
        hd = h;
      end
      vx = clip(vx + fmul(dvx, regs[REG_TIME_STEP]));
      vy = clip(vy + fmul(dvy, regs[REG_TIME_STEP]));
      px = clip(px + fmul(vx, regs[REG_TIME_STEP]));
      py = clip(py + fmul(vy, regs[REG_TIME_STEP]));
      s = '{px, py, vx, vy, hd & 64'h7FFFF};
      pending.push_back(s);
    endfunction

    function void compare(string name, longint e, longint a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(agent_state_t a);
      agent_state_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: position_x %0d position_y %0d", a.px, a.py);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare("position_x", e.px, a.px);
      compare("position_y", e.py, a.py);
      compare("velocity_x", e.vx, a.vx);
      compare("velocity_y", e.vy, a.vy);
      compare("heading", e.hd, a.hd);
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_write;
  logic [2:0]   cfg_index;
  logic [23:0]  cfg_data;
  longint       cycles;
  int           results_seen;
  int           burst_left;
  DynamicsScoreboard sb;

  sads_req_if req_ch();
  sads_res_if res_ch();

  swarm_agent_dynamics_step_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (req_ch),
    .result    (res_ch)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Cycle count and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result('{res_ch.position_x, res_ch.position_y, res_ch.velocity_x,
                        res_ch.velocity_y, longint'(res_ch.heading)});
      results_seen <= results_seen + 1;
    end
  end

  // Receiver: stall modes that change every stretch, plus one long hold-off
  initial begin
    int  mode;
    bit  held;
    held = 0;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 400)) begin
        @(posedge clk);
        case (mode)
          0, 1: res_ch.ready <= 1'b1;
          2:    res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      if (!held && results_seen >= 40) begin
        held = 1;
        @(posedge clk);
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until taken; bursts may end in random gaps
  task automatic send_request(agent_req_t r);
    req_ch.valid <= 1'b1;
    req_ch.op <= r.op;
    req_ch.neighbor_index <= r.slot;
    req_ch.neighbor_x <= r.nx[31:0];
    req_ch.neighbor_y <= r.ny[31:0];
    req_ch.connected_mask <= r.mask;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, $urandom_range(0, 1) ? 8 : 600)) @(posedge clk);
      end
    end
  endtask

  // Wait until the block is idle, then load all eight registers
  task automatic load_config(longint vals[8]);
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i][23:0];
      @(posedge clk);
      sb.write_reg(i, vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic agent_req_t step_req(logic [5:0] mask);
    agent_req_t r;
    r = '{OP_STEP, 3'($urandom), longint'($signed($urandom)),
          longint'($signed($urandom)), mask};
    return r;
  endfunction

  function automatic agent_req_t nb_req(logic [2:0] slot, longint nx, longint ny);
    agent_req_t r;
    r = '{OP_NB_WRITE, slot, nx, ny, 6'($urandom)};
    return r;
  endfunction

  // Neighbor whose target point sits exactly on the agent
  function automatic agent_req_t on_agent(int slot);
    return nb_req(slot[2:0], sb.clip(sb.px - sb.fmul(sb.regs[REG_SPACING], sb.hex_x[slot])),
                  sb.clip(sb.py - sb.fmul(sb.regs[REG_SPACING], sb.hex_y[slot])));
  endfunction

  function automatic longint pick_reg(int idx);
    longint top, dflt;
    top = (idx == REG_TIME_STEP) ? 64'hFFFF : 64'hFF_FFFF;
    dflt = sb.regs[idx];
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return top;
      2, 3:    return dflt;
      default: begin
        dflt = (dflt == 0 ? 64'd65536 : dflt) * $urandom_range(10, 300) / 100;
        return dflt > top ? top : dflt;
      end
    endcase
  endfunction

  // Mostly neighbors near the agent and steps; some wild values, bad slots and targets on the agent
  function automatic agent_req_t random_req();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 9) begin
      return step_req(6'($urandom));
    end else if (kind < 16) begin
      return nb_req(3'($urandom_range(0, 5)),
                    sb.clip(sb.px + $signed($urandom_range(0, 5242880)) - 2621440),
                    sb.clip(sb.py + $signed($urandom_range(0, 5242880)) - 2621440));
    end else if (kind < 18) begin
      return nb_req(3'($urandom), longint'($signed($urandom)),
                    longint'($signed($urandom)));
    end
    return on_agent($urandom_range(0, 5));
  endfunction

  initial begin
    longint vals[8];
    longint defaults[8];
    rst = 1'b1;
    cycles = 0;
    results_seen = 0;
    burst_left = 1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_NB_WRITE;
    req_ch.neighbor_index = '0;
    req_ch.neighbor_x = '0;
    req_ch.neighbor_y = '0;
    req_ch.connected_mask = '0;
    sb = new();
    defaults = sb.regs;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: plain step, field extremes, ignored slots, target on agent
    send_request(step_req(6'h00));
    send_request(nb_req(3'd0, 64'sd2147483647, -64'sd2147483648));
    send_request(nb_req(3'd5, -64'sd2147483648, 64'sd2147483647));
    send_request(nb_req(3'd6, 64'sd1000, 64'sd1000));
    send_request(nb_req(3'd7, -64'sd1, -64'sd1));
    send_request(step_req(6'h3F));
    send_request(on_agent(2));
    send_request(nb_req(3'd1, sb.px, sb.py + 64'sd655360));
    send_request(step_req(6'h06));

    // Bring the agent to rest, then a step at rest, then pull it downward
    vals = defaults;
    vals[REG_TIME_STEP] = 32768;
    vals[REG_VISCOSITY] = 131072;
    vals[REG_PROPULSION] = 0;
    vals[REG_SPRING] = 0;
    load_config(vals);
    send_request(step_req(6'h00));
    send_request(step_req(6'h00));
    vals[REG_VISCOSITY] = 0;
    vals[REG_SPRING] = 65536;
    load_config(vals);
    send_request(step_req(6'h00));
    send_request(step_req(6'h00));
    send_request(step_req(6'h00));

    // All registers at their top, then all at zero
    vals = '{64'hFFFF, 64'hFF_FFFF, 64'hFF_FFFF, 64'hFF_FFFF, 64'hFF_FFFF,
             64'hFF_FFFF, 64'hFF_FFFF, 64'hFF_FFFF};
    load_config(vals);
    send_request(step_req(6'h3F));
    send_request(step_req(6'h15));
    vals = '{0, 0, 0, 0, 0, 0, 0, 0};
    load_config(vals);
    send_request(step_req(6'h3F));
    send_request(nb_req(3'd4, 64'sd0, 64'sd0));
    send_request(step_req(6'h10));

    // Random phases, the first at the reset settings
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        vals = defaults;
      end else begin
        for (int i = 0; i < 8; i++) vals[i] = pick_reg(i);
        // bring the agent back inside range now and then
        if ($urandom_range(0, 2) == 0) vals[REG_SPRING] = 65536;
      end
      load_config(vals);
      repeat (100) send_request(random_req());
    end

    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/sads_pkg.sv
design/sads_req_if.sv
design/sads_res_if.sv
design/sads_ctrl.sv
design/sads_dp.sv
design/swarm_agent_dynamics_step_core.sv
verif/tb.sv
